>>> rtl/tracking_frame_deframer_macros.svh
// Assertion macros used by the checker file of the tracking frame deframer.
`ifndef TRACKING_FRAME_DEFRAMER_MACROS_SVH
`define TRACKING_FRAME_DEFRAMER_MACROS_SVH

// Same-cycle implication, sampled at the rising clock edge, off during reset.
`define TFD_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled at the rising clock edge, off during reset.
`define TFD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/tfd_pkg.sv
// ---------------------------------------------------------------------------
// Tracking frame deframer package
// Shared widths, codes and defaults of the tracking frame deframer.
// ---------------------------------------------------------------------------
package tfd_pkg;

   localparam int BYTE_W         = 8;
   localparam int KIND_W         = 3;
   localparam int RECORD_W       = 13;
   localparam int OFFSET_W       = 9;
   localparam int STAMP_W        = 64;
   localparam int ERROR_W        = 3;
   localparam int LIMIT_W        = 16;
   localparam int SECTION_W      = 9;
   localparam int STAMP_BYTES    = 8;

   localparam int TRANSFORM_WORDS_DEFAULT = 16;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'hFFFF;

   typedef enum logic [1:0] {
      PH_STAMP   = 2'd0,
      PH_NAME    = 2'd1,
      PH_XFORM   = 2'd2,
      PH_DISCARD = 2'd3
   } phase_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_STAMP     = 3'd0,
      KIND_NAME_CHAR = 3'd1,
      KIND_NAME_END  = 3'd2,
      KIND_XFORM     = 3'd3,
      KIND_DISCARD   = 3'd4
   } kind_type;

   typedef enum logic [ERROR_W-1:0] {
      ERR_NONE       = 3'd0,
      ERR_SHORT      = 3'd1,
      ERR_ZERO_STAMP = 3'd2,
      ERR_OPEN_NAME  = 3'd3,
      ERR_CUT_XFORM  = 3'd4,
      ERR_OVER_LIMIT = 3'd5
   } error_type;

endpackage

>>> rtl/tfd_channels.sv
// ---------------------------------------------------------------------------
// Tracking frame deframer channels
// Valid/ready channels for requests, results and the limit register write.
// ---------------------------------------------------------------------------
interface tfd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] payload_byte;
   logic       last_byte;

   modport source (output valid, payload_byte, last_byte, input ready);
   modport sink   (input valid, payload_byte, last_byte, output ready);
endinterface

interface tfd_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  byte_kind;
   logic [7:0]  byte_out;
   logic [12:0] record_index;
   logic [8:0]  transform_offset;
   logic        record_done;
   logic [63:0] timestamp;
   logic        timestamp_valid;
   logic        frame_end;
   logic [12:0] record_count;
   logic [2:0]  error_code;

   modport source (output valid, byte_kind, byte_out, record_index, transform_offset,
                   record_done, timestamp, timestamp_valid, frame_end, record_count,
                   error_code, input ready);
   modport sink   (input valid, byte_kind, byte_out, record_index, transform_offset,
                   record_done, timestamp, timestamp_valid, frame_end, record_count,
                   error_code, output ready);
endinterface

interface tfd_csr_if;
   logic        valid;
   logic        ready;
   logic [15:0] frame_byte_limit;

   modport source (output valid, frame_byte_limit, input ready);
   modport sink   (input valid, frame_byte_limit, output ready);
endinterface

>>> rtl/tracking_frame_deframer.sv
// ---------------------------------------------------------------------------
// Tracking frame deframer
// Splits tracking datagrams into timestamp, record names and transform bytes.
// ---------------------------------------------------------------------------
// Every payload request yields exactly one result, in the cycle after it is
// accepted, and a new request is taken in every cycle as long as the result
// register is empty or its result is being taken in the same cycle, so the
// block sustains one byte per clock; the single result register is the only
// thing that sets this figure. The result for the last byte of a datagram
// carries the record count or the first error found, and the parser then
// starts over for the next datagram. The frame length limit register is
// always writable and should only be changed between frames.
module tracking_frame_deframer
   import tfd_pkg::*;
#(
   parameter int TRANSFORM_WORDS = TRANSFORM_WORDS_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   tfd_req_if.sink   req_chan,
   tfd_rsp_if.source rsp_chan,
   tfd_csr_if.sink   csr_chan
);

   localparam int XFORM_BYTES = TRANSFORM_WORDS * 8;
   localparam logic [SECTION_W-1:0] XFORM_LAST = SECTION_W'(XFORM_BYTES - 1);
   localparam logic [RECORD_W-1:0]  RECORD_MAX = '1;
   localparam logic [LIMIT_W-1:0]   BYTES_MAX  = '1;

   // Parser state.
   phase_type              phase_ff, phase_in, phase_step;
   logic [SECTION_W-1:0]   section_ff, section_in, section_step;
   logic [STAMP_W-1:0]     stamp_ff, stamp_in, stamp_step, stamp_merged;
   logic [RECORD_W-1:0]    records_ff, records_in, records_step;
   logic [LIMIT_W-1:0]     bytes_ff, bytes_in;
   logic [ERROR_W-1:0]     error_ff, error_in, error_step;
   logic [LIMIT_W-1:0]     limit_ff, limit_in;

   // Result register.
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [KIND_W-1:0]      kind_ff, kind_in;
   logic [BYTE_W-1:0]      byte_ff;
   logic [RECORD_W-1:0]    index_ff, index_in;
   logic [OFFSET_W-1:0]    offset_ff, offset_in;
   logic                   done_ff, done_in;
   logic [STAMP_W-1:0]     stamp_out_ff, stamp_out_in;
   logic                   stamp_ok_ff, stamp_ok_in;
   logic                   end_ff;
   logic [RECORD_W-1:0]    count_ff, count_in;
   logic [ERROR_W-1:0]     code_ff, code_in;

   logic                   accept;
   logic [BYTE_W-1:0]      data;
   logic                   last;
   logic [LIMIT_W:0]       position;
   logic                   over_limit;
   logic                   stamp_last;
   logic                   xform_last;

   assign data   = req_chan.payload_byte;
   assign last   = req_chan.last_byte;
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept = req_chan.valid && req_chan.ready;
   assign csr_chan.ready = 1'b1;

   assign position   = {1'b0, bytes_ff} + {{LIMIT_W{1'b0}}, 1'b1};
   assign over_limit = (phase_ff != PH_DISCARD) && (error_ff == ERR_NONE)
                       && (position > {1'b0, limit_ff});
   assign stamp_last = (section_ff[2:0] == 3'(STAMP_BYTES - 1));
   assign xform_last = (section_ff == XFORM_LAST);

   // The stamp arrives little-endian: each byte lands in its own lane.
   always_comb begin
      stamp_merged = stamp_ff;
      for (int i = 0; i < STAMP_BYTES; i++) begin
         if (section_ff[2:0] == 3'(i)) begin
            stamp_merged[i*BYTE_W +: BYTE_W] = stamp_ff[i*BYTE_W +: BYTE_W] | data;
         end
      end
   end

   // Next state of the parser for one request, before the end-of-frame clear.
   always_comb begin
      phase_step   = phase_ff;
      section_step = section_ff;
      stamp_step   = stamp_ff;
      records_step = records_ff;
      error_step   = error_ff;
      if (over_limit) begin
         error_step = ERR_OVER_LIMIT;
         phase_step = PH_DISCARD;
      end else begin
         case (phase_ff)
            PH_STAMP: begin
               stamp_step = stamp_merged;
               if (stamp_last) begin
                  section_step = '0;
                  if (stamp_merged == '0) begin
                     if (error_ff == ERR_NONE) error_step = ERR_ZERO_STAMP;
                     phase_step = PH_DISCARD;
                  end else begin
                     phase_step = PH_NAME;
                  end
               end else begin
                  section_step = section_ff + 1'b1;
                  if (last) begin
                     if (error_ff == ERR_NONE) error_step = ERR_SHORT;
                     phase_step = PH_DISCARD;
                  end
               end
            end
            PH_NAME: begin
               if (data != '0) begin
                  if (last) begin
                     if (error_ff == ERR_NONE) error_step = ERR_OPEN_NAME;
                     phase_step = PH_DISCARD;
                  end
               end else begin
                  section_step = '0;
                  phase_step   = PH_XFORM;
                  if (last) begin
                     if (error_ff == ERR_NONE) error_step = ERR_CUT_XFORM;
                     phase_step = PH_DISCARD;
                  end
               end
            end
            PH_XFORM: begin
               if (xform_last) begin
                  section_step = '0;
                  if (records_ff != RECORD_MAX) records_step = records_ff + 1'b1;
                  phase_step = PH_NAME;
               end else begin
                  section_step = section_ff + 1'b1;
                  if (last) begin
                     if (error_ff == ERR_NONE) error_step = ERR_CUT_XFORM;
                     phase_step = PH_DISCARD;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   // State registers load on an accepted request; the last byte clears the frame.
   always_comb begin
      phase_in   = phase_ff;
      section_in = section_ff;
      stamp_in   = stamp_ff;
      records_in = records_ff;
      bytes_in   = bytes_ff;
      error_in   = error_ff;
      limit_in   = csr_chan.valid ? csr_chan.frame_byte_limit : limit_ff;
      if (accept) begin
         if (last) begin
            phase_in   = PH_STAMP;
            section_in = '0;
            stamp_in   = '0;
            records_in = '0;
            bytes_in   = '0;
            error_in   = ERR_NONE;
         end else begin
            phase_in   = phase_step;
            section_in = section_step;
            stamp_in   = stamp_step;
            records_in = records_step;
            bytes_in   = (bytes_ff == BYTES_MAX) ? bytes_ff : position[LIMIT_W-1:0];
            error_in   = error_step;
         end
      end
   end

   // Result fields for the request being accepted.
   always_comb begin
      kind_in      = KIND_DISCARD;
      index_in     = '0;
      offset_in    = '0;
      done_in      = 1'b0;
      stamp_out_in = '0;
      stamp_ok_in  = 1'b0;
      if (!over_limit) begin
         case (phase_ff)
            PH_STAMP: begin
               kind_in = KIND_STAMP;
               if (stamp_last && (stamp_merged != '0)) begin
                  stamp_ok_in  = 1'b1;
                  stamp_out_in = stamp_merged;
               end
            end
            PH_NAME: begin
               kind_in  = (data != '0) ? KIND_NAME_CHAR : KIND_NAME_END;
               index_in = records_ff;
            end
            PH_XFORM: begin
               kind_in   = KIND_XFORM;
               index_in  = records_ff;
               offset_in = OFFSET_W'(section_ff);
               done_in   = xform_last;
            end
            default: begin
            end
         endcase
      end
      count_in = (last && (error_step == ERR_NONE)) ? records_step : '0;
      code_in  = last ? error_step : ERR_NONE;
   end

   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_STAMP;
         section_ff   <= '0;
         stamp_ff     <= '0;
         records_ff   <= '0;
         bytes_ff     <= '0;
         error_ff     <= ERR_NONE;
         limit_ff     <= LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         section_ff   <= section_in;
         stamp_ff     <= stamp_in;
         records_ff   <= records_in;
         bytes_ff     <= bytes_in;
         error_ff     <= error_in;
         limit_ff     <= limit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff      <= kind_in;
         byte_ff      <= data;
         index_ff     <= index_in;
         offset_ff    <= offset_in;
         done_ff      <= done_in;
         stamp_out_ff <= stamp_out_in;
         stamp_ok_ff  <= stamp_ok_in;
         end_ff       <= last;
         count_ff     <= count_in;
         code_ff      <= code_in;
      end
   end

   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.byte_kind        = kind_ff;
   assign rsp_chan.byte_out         = byte_ff;
   assign rsp_chan.record_index     = index_ff;
   assign rsp_chan.transform_offset = offset_ff;
   assign rsp_chan.record_done      = done_ff;
   assign rsp_chan.timestamp        = stamp_out_ff;
   assign rsp_chan.timestamp_valid  = stamp_ok_ff;
   assign rsp_chan.frame_end        = end_ff;
   assign rsp_chan.record_count     = count_ff;
   assign rsp_chan.error_code       = code_ff;

endmodule

>>> rtl/tfd_checker.sv
// ---------------------------------------------------------------------------
// Tracking frame deframer checker
// Port-level assertions on the deframer, attached to the top level by bind.
// ---------------------------------------------------------------------------
`include "tracking_frame_deframer_macros.svh"

module tfd_checker
   import tfd_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  rsp_byte_kind,
   input logic [8:0]  rsp_transform_offset,
   input logic        rsp_record_done,
   input logic [63:0] rsp_timestamp,
   input logic        rsp_timestamp_valid,
   input logic        rsp_frame_end,
   input logic [12:0] rsp_record_count,
   input logic [2:0]  rsp_error_code
);

   // A result that is not taken must still be offered in the next cycle.
   `TFD_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "result dropped while stalled")

   // Every accepted request produces a result in the following cycle.
   `TFD_ASSERT_NEXT(a_req_to_rsp, req_valid && req_ready, rsp_valid, "request gave no result")

   // Count and error are reported only with the end of a frame.
   `TFD_ASSERT_NOW(a_end_only, rsp_valid && !rsp_frame_end, (rsp_record_count == '0) && (rsp_error_code == ERR_NONE), "frame status outside frame end")

   // The timestamp field is zero unless it is flagged valid.
   `TFD_ASSERT_NOW(a_stamp_zero, rsp_valid && !rsp_timestamp_valid, rsp_timestamp == '0, "timestamp shown without valid flag")

   // Offsets and record completion belong to transform bytes only.
   `TFD_ASSERT_NOW(a_xform_tags, rsp_valid && (rsp_byte_kind != KIND_XFORM), (rsp_transform_offset == '0) && !rsp_record_done, "transform tag on another kind")

endmodule

bind tracking_frame_deframer tfd_checker u_tfd_checker (
   .clock                (clock),
   .reset                (reset),
   .req_valid            (req_chan.valid),
   .req_ready            (req_chan.ready),
   .rsp_valid            (rsp_chan.valid),
   .rsp_ready            (rsp_chan.ready),
   .rsp_byte_kind        (rsp_chan.byte_kind),
   .rsp_transform_offset (rsp_chan.transform_offset),
   .rsp_record_done      (rsp_chan.record_done),
   .rsp_timestamp        (rsp_chan.timestamp),
   .rsp_timestamp_valid  (rsp_chan.timestamp_valid),
   .rsp_frame_end        (rsp_chan.frame_end),
   .rsp_record_count     (rsp_chan.record_count),
   .rsp_error_code       (rsp_chan.error_code)
);

>>> sim/tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Tracking frame deframer testbench
// Sends directed and random datagrams under several frame length limits.
// Predicts the tag of every byte and checks each result in order against it.
// ---------------------------------------------------------------------------
module tb;
   import tfd_pkg::*;

   localparam int XFORM_BYTES  = TRANSFORM_WORDS_DEFAULT * 8;
   localparam int HOLD_CYCLES  = 300;
   localparam int CYCLE_LIMIT  = 1000000;
   localparam int REPORT_LIMIT = 10;

   typedef struct {
      kind_type    kind;
      logic [7:0]  data;
      logic [12:0] rec;
      logic [8:0]  offs;
      logic        done;
      logic [63:0] stamp;
      logic        stamp_ok;
      logic        fend;
      logic [12:0] count;
      error_type   err;
   } byte_tag_type;

   typedef enum int {
      SHAPE_GOOD, SHAPE_CUT, SHAPE_SHORT, SHAPE_ZERO_STAMP, SHAPE_NOISE
   } frame_shape_type;

   class frame_tag_board;
      logic [15:0]  byte_limit;
      phase_type    phase;
      int unsigned  section;
      logic [63:0]  stamp_acc;
      logic [12:0]  records;
      int unsigned  position;
      error_type    first_error;
      byte_tag_type pending_tags[$];
      int unsigned  tag_errors;

      function new();
         byte_limit = LIMIT_RESET;
         tag_errors = 0;
         clear_frame();
      endfunction

      function void clear_frame();
         phase       = PH_STAMP;
         section     = 0;
         stamp_acc   = '0;
         records     = '0;
         position    = 0;
         first_error = ERR_NONE;
      endfunction

      function void flag_error(error_type code);
         if (first_error == ERR_NONE) begin
            first_error = code;
         end
         phase = PH_DISCARD;
      endfunction

      function void note_request(logic [7:0] data, logic last);
         byte_tag_type t;
         int unsigned  pos;
         t.kind     = KIND_DISCARD;
         t.data     = data;
         t.rec      = '0;
         t.offs     = '0;
         t.done     = 1'b0;
         t.stamp    = '0;
         t.stamp_ok = 1'b0;
         pos        = position + 1;
         position   = (pos > 65535) ? 65535 : pos;
         if (phase != PH_DISCARD && first_error == ERR_NONE && pos > byte_limit) begin
            flag_error(ERR_OVER_LIMIT);
         end else begin
            case (phase)
               PH_STAMP: begin
                  t.kind    = KIND_STAMP;
                  stamp_acc = stamp_acc | (64'(data) << (8 * section));
                  section++;
                  if (section >= 8) begin
                     section = 0;
                     if (stamp_acc == 0) begin
                        flag_error(ERR_ZERO_STAMP);
                     end else begin
                        t.stamp_ok = 1'b1;
                        t.stamp    = stamp_acc;
                        phase      = PH_NAME;
                     end
                  end else if (last) begin
                     flag_error(ERR_SHORT);
                  end
               end
               PH_NAME: begin
                  t.rec = records;
                  if (data != 0) begin
                     t.kind = KIND_NAME_CHAR;
                     if (last) flag_error(ERR_OPEN_NAME);
                  end else begin
                     t.kind  = KIND_NAME_END;
                     section = 0;
                     phase   = PH_XFORM;
                     if (last) flag_error(ERR_CUT_XFORM);
                  end
               end
               PH_XFORM: begin
                  t.kind = KIND_XFORM;
                  t.rec  = records;
                  t.offs = 9'(section);
                  section++;
                  if (section >= XFORM_BYTES) begin
                     t.done  = 1'b1;
                     section = 0;
                     if (records != 13'h1FFF) records++;
                     phase = PH_NAME;
                  end else if (last) begin
                     flag_error(ERR_CUT_XFORM);
                  end
               end
               default: ;
            endcase
         end
         t.fend  = last;
         t.count = (last && first_error == ERR_NONE) ? records : 13'd0;
         t.err   = last ? first_error : ERR_NONE;
         pending_tags.push_back(t);
         if (last) clear_frame();
      endfunction

      function string describe(byte_tag_type t);
         return $sformatf({"kind=%0d byte=%02h rec=%0d offs=%0d done=%0b ts=%016h",
                           " tsv=%0b end=%0b count=%0d err=%0d"},
                          t.kind, t.data, t.rec, t.offs, t.done, t.stamp,
                          t.stamp_ok, t.fend, t.count, t.err);
      endfunction

      function void check_result(byte_tag_type got);
         byte_tag_type want;
         bit           ok;
         if (pending_tags.size() == 0) begin
            tag_errors++;
            if (tag_errors <= REPORT_LIMIT) begin
               $display("result without a pending request: %s", describe(got));
            end
            return;
         end
         want = pending_tags.pop_front();
         ok = (got.kind === want.kind) && (got.data === want.data) &&
              (got.rec === want.rec) && (got.offs === want.offs) &&
              (got.done === want.done) && (got.stamp === want.stamp) &&
              (got.stamp_ok === want.stamp_ok) && (got.fend === want.fend) &&
              (got.count === want.count) && (got.err === want.err);
         if (!ok) begin
            tag_errors++;
            if (tag_errors <= REPORT_LIMIT) begin
               $display("result mismatch");
               $display("  expected %s", describe(want));
               $display("  actual   %s", describe(got));
            end
         end
      endfunction
   endclass

   logic           clock = 1'b0;
   logic           reset;
   bit             idling_on;
   bit             hold_off_pending;
   int unsigned    cycle_count = 0;
   logic [7:0]     frame_q[$];
   frame_tag_board tags;

   tfd_req_if req_chan ();
   tfd_rsp_if rsp_chan ();
   tfd_csr_if csr_chan ();

   tracking_frame_deframer i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Register writes and requests are applied to the prediction before results
   // are checked, so the order of the processes within a step does not matter.
   always @(posedge clock) begin : watch
      byte_tag_type got;
      if (!reset) begin
         if (csr_chan.valid && csr_chan.ready) begin
            tags.byte_limit = csr_chan.frame_byte_limit;
         end
         if (req_chan.valid && req_chan.ready) begin
            tags.note_request(req_chan.payload_byte, req_chan.last_byte);
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            got.kind     = kind_type'(rsp_chan.byte_kind);
            got.data     = rsp_chan.byte_out;
            got.rec      = rsp_chan.record_index;
            got.offs     = rsp_chan.transform_offset;
            got.done     = rsp_chan.record_done;
            got.stamp    = rsp_chan.timestamp;
            got.stamp_ok = rsp_chan.timestamp_valid;
            got.fend     = rsp_chan.frame_end;
            got.count    = rsp_chan.record_count;
            got.err      = error_type'(rsp_chan.error_code);
            tags.check_result(got);
         end
      end
   end

   function automatic int pick_gap();
      int roll;
      if (!idling_on) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 88) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   initial begin : receiver
      int gap;
      rsp_chan.ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (hold_off_pending) begin
            hold_off_pending = 1'b0;
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            gap = pick_gap();
            if (gap > 0) begin
               rsp_chan.ready <= 1'b0;
               repeat (gap) @(posedge clock);
            end
            rsp_chan.ready <= 1'b1;
            repeat ($urandom_range(1, 40)) @(posedge clock);
         end
      end
   end

   // Valid is only lowered for a gap, so back-to-back requests keep it high.
   task automatic send_request(logic [7:0] data, logic last);
      int gap;
      req_chan.valid        <= 1'b1;
      req_chan.payload_byte <= data;
      req_chan.last_byte    <= last;
      do @(posedge clock); while (!req_chan.ready);
      gap = pick_gap();
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_frame();
      for (int i = 0; i < frame_q.size(); i++) begin
         send_request(frame_q[i], i == frame_q.size() - 1);
      end
   endtask

   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (tags.pending_tags.size() != 0);
   endtask

   task automatic write_byte_limit(logic [15:0] value);
      csr_chan.valid            <= 1'b1;
      csr_chan.frame_byte_limit <= value;
      do @(posedge clock); while (!csr_chan.ready);
      csr_chan.valid <= 1'b0;
   endtask

   function automatic void push_random(int count);
      repeat (count) frame_q.push_back(8'($urandom_range(0, 255)));
   endfunction

   function automatic void push_name(int len);
      repeat (len) frame_q.push_back(8'($urandom_range(1, 255)));
   endfunction

   function automatic int pick_name_len();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 20) return 0;
      if (roll < 90) return $urandom_range(1, 5);
      return $urandom_range(6, 24);
   endfunction

   function automatic void build_frame(frame_shape_type shape);
      int records;
      int roll;
      bit nonzero;
      frame_q.delete();
      case (shape)
         SHAPE_SHORT: push_random($urandom_range(1, 7));
         SHAPE_ZERO_STAMP: begin
            repeat (8) frame_q.push_back(8'h00);
            push_random($urandom_range(0, 12));
         end
         SHAPE_NOISE: push_random($urandom_range(9, 60));
         default: begin
            // Stamp bytes are often zero, but never all of them.
            nonzero = 1'b0;
            for (int i = 0; i < 8; i++) begin
               frame_q.push_back(($urandom_range(0, 3) == 0) ? 8'h00
                                                             : 8'($urandom_range(1, 255)));
               if (frame_q[i] != 8'h00) nonzero = 1'b1;
            end
            if (!nonzero) frame_q[$urandom_range(0, 7)] = 8'($urandom_range(1, 255));
            roll    = $urandom_range(0, 9);
            records = (roll < 3) ? 0 : (roll < 7) ? 1 : (roll < 9) ? 2 : 3;
            repeat (records) begin
               push_name(pick_name_len());
               frame_q.push_back(8'h00);
               push_random(XFORM_BYTES);
            end
            // A cut frame ends inside a name, on a terminator or inside the transform.
            if (shape == SHAPE_CUT) begin
               roll = $urandom_range(0, 2);
               if (roll == 0) begin
                  push_name($urandom_range(1, 6));
               end else begin
                  push_name(pick_name_len());
                  frame_q.push_back(8'h00);
                  if (roll == 2) push_random($urandom_range(1, XFORM_BYTES - 1));
               end
            end
         end
      endcase
   endfunction

   task automatic run_frames(int budget);
      int              sent;
      int              roll;
      frame_shape_type shape;
      sent = 0;
      while (sent < budget) begin
         idling_on = ($urandom_range(0, 9) < 7);
         roll  = $urandom_range(0, 99);
         shape = (roll < 45) ? SHAPE_GOOD :
                 (roll < 75) ? SHAPE_CUT :
                 (roll < 85) ? SHAPE_SHORT :
                 (roll < 93) ? SHAPE_ZERO_STAMP : SHAPE_NOISE;
         build_frame(shape);
         send_frame();
         sent += frame_q.size();
      end
   endtask

   initial begin
      tags             = new();
      idling_on        = 1'b1;
      hold_off_pending = 1'b0;
      reset                     <= 1'b1;
      req_chan.valid            <= 1'b0;
      req_chan.payload_byte     <= 8'h00;
      req_chan.last_byte        <= 1'b0;
      csr_chan.valid            <= 1'b0;
      csr_chan.frame_byte_limit <= LIMIT_RESET;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // A one-byte frame, an all-zero stamp, and stamp-only frames at both
      // extremes of a nonzero stamp.
      frame_q = '{8'hFF};
      send_frame();
      frame_q = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
      send_frame();
      frame_q = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
      send_frame();
      frame_q = '{8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
      send_frame();

      // The result side stops for a long while and the request side keeps offering bytes.
      hold_off_pending = 1'b1;
      run_frames(300);
      wait_drained();
      run_frames(250);
      wait_drained();
      write_byte_limit(16'd8);
      run_frames(100);
      wait_drained();
      write_byte_limit(16'($urandom_range(9, 300)));
      run_frames(300);
      wait_drained();
      write_byte_limit(LIMIT_RESET);
      run_frames(350);
      wait_drained();
      repeat (4) @(posedge clock);

      if (tags.pending_tags.size() != 0) begin
         $display("%0d results never arrived", tags.pending_tags.size());
      end
      if (tags.tag_errors == 0 && tags.pending_tags.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
